/* src/jbp_pkg.sv */
// Shared types and constants for the JPEG bit packer.
`timescale 1ns / 1ps

package jbp_pkg;

  localparam int unsigned AccW      = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MaxCodeW  = 16;
  localparam logic [7:0]  StuffMark = 8'hFF;
  localparam logic [7:0]  StuffByte = 8'h00;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_ALIGN = 2'd1,
    ACT_RAW   = 2'd2
  } jbp_action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [7:0]  raw_byte;
  } jbp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } jbp_out_t;

  // One queued job: one or two bytes, stuffed unless raw.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       raw;
  } jbp_job_t;

endpackage

/* src/jbp_stream_if.sv */
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps

interface jbp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/jbp_front.sv */
// Front end: accepts items, packs code bits and queues byte jobs.
`timescale 1ns / 1ps

module jbp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  jbp_pkg::jbp_in_t  in_data_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output jbp_pkg::jbp_job_t job_o
);

  logic [15:0] acc_q, acc_d;
  logic [3:0]  held_q, held_d;

  logic        accept;
  logic [4:0]  len_c;
  logic [16:0] code_mask;
  logic [4:0]  pad_len;
  logic [16:0] pad_mask;
  logic [4:0]  p_len;
  logic [15:0] p_bits;
  logic [4:0]  total;
  logic [5:0]  shamt;
  logic [31:0] wide;
  logic        fill;
  logic [15:0] put_acc;
  logic        job_valid;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    len_c     = (in_data_i.code_length > 5'(jbp_pkg::MaxCodeW)) ?
                5'(jbp_pkg::MaxCodeW) : in_data_i.code_length;
    code_mask = (17'd1 << len_c) - 17'd1;
    pad_len   = 5'(jbp_pkg::ByteW) - {2'b00, held_q[2:0]};
    pad_mask  = (17'd1 << pad_len) - 17'd1;

    if (in_data_i.action == jbp_pkg::ACT_PUT) begin
      p_len  = len_c;
      p_bits = in_data_i.code_bits & code_mask[15:0];
    end else begin
      // pad with ones up to the next byte boundary, none when aligned
      p_len  = (held_q[2:0] != 3'd0) ? pad_len : 5'd0;
      p_bits = (held_q[2:0] != 3'd0) ? pad_mask[15:0] : 16'h0000;
    end

    total   = {1'b0, held_q} + p_len;
    shamt   = 6'd32 - {1'b0, total};
    wide    = {acc_q, 16'h0000} | ({16'h0000, p_bits} << shamt);
    fill    = total[4];
    put_acc = fill ? wide[15:0] : wide[31:16];

    acc_d     = acc_q;
    held_d    = held_q;
    job_valid = 1'b0;
    job_o     = '{byte0: wide[31:24], byte1: wide[23:16], two: 1'b1, raw: 1'b0};

    case (in_data_i.action)
      jbp_pkg::ACT_PUT: begin
        if (in_data_i.code_length != 5'd0) begin
          acc_d     = put_acc;
          held_d    = total[3:0];
          job_valid = fill;
        end
      end
      jbp_pkg::ACT_ALIGN: begin
        acc_d     = put_acc;
        held_d    = total[3:0];
        job_valid = fill;
        // one whole byte left after padding: flush it and empty
        if (!fill && total[3:0] == 4'(jbp_pkg::ByteW)) begin
          job_o.byte0 = put_acc[15:8];
          job_o.two   = 1'b0;
          job_valid   = 1'b1;
          acc_d       = '0;
          held_d      = '0;
        end
      end
      jbp_pkg::ACT_RAW: begin
        job_o.byte0 = in_data_i.raw_byte;
        job_o.two   = 1'b0;
        job_o.raw   = 1'b1;
        job_valid   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign push_o = accept && job_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

endmodule

/* src/jbp_job_fifo.sv */
// Small flop-based queue of byte jobs between front and back.
`timescale 1ns / 1ps

module jbp_job_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jbp_pkg::jbp_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output jbp_pkg::jbp_job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jbp_pkg::jbp_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

/* src/jbp_back.sv */
// Back end: serializes queued jobs into bytes, inserting stuff bytes.
`timescale 1ns / 1ps

module jbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  jbp_pkg::jbp_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  output jbp_pkg::jbp_out_t out_data_o,
  input  logic              out_ready_i
);

  logic              idx_q, idx_d;
  logic              stuff_q, stuff_d;
  logic              ovalid_q, ovalid_d;
  jbp_pkg::jbp_out_t out_q, out_d;

  logic       load;
  logic [7:0] cur;
  logic       final_byte;
  logic       need_stuff;

  assign load       = (!ovalid_q || out_ready_i) && job_valid_i;
  assign cur        = idx_q ? job_i.byte1 : job_i.byte0;
  assign final_byte = (idx_q == job_i.two);
  assign need_stuff = !job_i.raw && (cur == jbp_pkg::StuffMark);

  always_comb begin
    idx_d    = idx_q;
    stuff_d  = stuff_q;
    out_d    = out_q;
    pop_o    = 1'b0;
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
      if (stuff_q) begin
        out_d   = '{out_byte: jbp_pkg::StuffByte, last: final_byte};
        stuff_d = 1'b0;
        pop_o   = final_byte;
        idx_d   = final_byte ? 1'b0 : 1'b1;
      end else begin
        out_d = '{out_byte: cur, last: final_byte && !need_stuff};
        if (need_stuff) begin
          stuff_d = 1'b1;
        end else begin
          pop_o = final_byte;
          idx_d = final_byte ? 1'b0 : 1'b1;
        end
      end
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 1'b0;
      stuff_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      stuff_q  <= stuff_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

/* src/jpeg_bit_packer_with_stuffing_top.sv */
// Top level of the JPEG entropy bit packer with 0xFF/0x00 stuffing.
`timescale 1ns / 1ps

// The packer takes one input beat per cycle as long as its four-entry job
// queue has room; a beat is classified and packed into the 16-bit
// accumulator in the cycle it is accepted. The output side emits one byte
// per cycle while the receiver is ready, from a registered output stage. An
// item causes one to four output bytes (two data bytes, each possibly
// followed by a 0x00 stuff byte), and none for items that only fill the
// accumulator. Sustained throughput is therefore set by the byte
// serializer. The first byte of an item passes through the job queue and
// the registered output stage before it is offered on the output.

module jpeg_bit_packer_with_stuffing_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  jbp_stream_if.sink   in_i,
  jbp_stream_if.source out_o
);

  logic              q_full;
  logic              push;
  logic              pop;
  logic              q_valid;
  jbp_pkg::jbp_job_t push_job;
  jbp_pkg::jbp_job_t head_job;

  jbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.payload),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  jbp_job_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  jbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.payload),
    .out_ready_i (out_o.ready)
  );

endmodule

/* src/jbp_checker.sv */
// Port-level assertions for the bit packer, bound to the top level.
`timescale 1ns / 1ps

module jbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // hold a stalled output beat
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_last_i))
    else $error("output payload changed while stalled");

  // a 0xFF that is not the final byte of its item is followed at once by 0x00
  a_stuff_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_byte_i == 8'hFF && !out_last_i
    |=> out_valid_i && out_byte_i == 8'h00)
    else $error("stuff byte missing after 0xFF");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind jpeg_bit_packer_with_stuffing_top jbp_checker u_jbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.payload.out_byte),
  .out_last_i  (out_o.payload.last)
);

/* verif/testbench.sv */
// Self-checking testbench for the JPEG bit packer with 0xFF/0x00 byte stuffing.
`timescale 1ns / 1ps

module testbench;
  import jbp_pkg::*;

  localparam logic [1:0]  ActUnused  = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned HoldCycles = 150;

  typedef struct {
    jbp_in_t     beat;
    bit          drain_first;
    int unsigned phase;
  } beat_stim_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jbp_stream_if #(.T(jbp_in_t))  in_if ();
  jbp_stream_if #(.T(jbp_out_t)) out_if ();

  jpeg_bit_packer_with_stuffing_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #6 clk_i = ~clk_i;

  // Idle percentages per phase: none, sender, receiver, both.
  int unsigned src_idle_pct   [4] = '{0, 64, 0, 21};
  int unsigned sink_stall_pct [4] = '{0, 0, 64, 21};

  beat_stim_t  pending_beats_q[$];
  jbp_out_t    expected_bytes_q[$];
  logic [7:0]  item_bytes_q[$];

  // Packer state as the block should hold it.
  logic [15:0] packed_bits_r;
  logic [3:0]  held_cnt_r;

  int unsigned cur_phase;
  logic        sink_hold_r;
  int unsigned stall_cycles;
  int unsigned err_cnt;
  int unsigned beats_in;
  int unsigned bytes_out;
  int unsigned stuff_cnt;
  int unsigned n_put, n_align, n_raw, n_ignored;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void stage_byte(input logic [7:0] b);
    item_bytes_q.push_back(b);
    if (b == StuffMark) begin
      item_bytes_q.push_back(StuffByte);
      stuff_cnt++;
    end
  endfunction

  // Append len (1..16) bits MSB first; emit both bytes once 16 are held.
  function automatic void append_bits(input logic [15:0] bits, input int unsigned len);
    int unsigned total;
    logic [31:0] mask;
    logic [31:0] wide;
    total = held_cnt_r + len;
    mask  = (32'd1 << len) - 32'd1;
    wide  = {packed_bits_r, 16'h0000} | ((32'(bits) & mask) << (2 * AccW - total));
    if (total >= AccW) begin
      stage_byte(wide[31:24]);
      stage_byte(wide[23:16]);
      packed_bits_r = wide[15:0];
      held_cnt_r    = 4'(total - AccW);
    end else begin
      packed_bits_r = wide[31:16];
      held_cnt_r    = 4'(total);
    end
  endfunction

  task automatic pack_expected_bytes(input jbp_in_t b);
    int unsigned len;
    int unsigned frac;
    jbp_out_t    res;
    item_bytes_q.delete();
    len = (b.code_length > MaxCodeW) ? MaxCodeW : b.code_length;
    case (b.action)
      ACT_PUT: begin
        n_put++;
        if (len != 0) append_bits(b.code_bits, len);
      end
      ACT_ALIGN: begin
        n_align++;
        frac = held_cnt_r % ByteW;
        if (frac != 0) append_bits(16'((32'd1 << (ByteW - frac)) - 32'd1), ByteW - frac);
        if (held_cnt_r == ByteW) begin
          stage_byte(packed_bits_r[15:8]);
          packed_bits_r = '0;
          held_cnt_r    = '0;
        end
      end
      ACT_RAW: begin
        n_raw++;
        item_bytes_q.push_back(b.raw_byte);
      end
      default: n_ignored++;
    endcase
    foreach (item_bytes_q[i]) begin
      res.out_byte = item_bytes_q[i];
      res.last     = (i == item_bytes_q.size() - 1);
      expected_bytes_q.push_back(res);
    end
  endtask

  function automatic void add_beat(input logic [1:0] act, input logic [15:0] code,
                                   input logic [4:0] len, input logic [7:0] raw,
                                   input bit drain, input int unsigned phase);
    beat_stim_t s;
    s.beat.action      = act;
    s.beat.code_bits   = code;
    s.beat.code_length = len;
    s.beat.raw_byte    = raw;
    s.drain_first      = drain;
    s.phase            = phase;
    pending_beats_q.push_back(s);
  endfunction

  // Mostly well-formed codes; some stray bits, oversized lengths and ignored beats.
  task automatic add_random_beats(input int unsigned phase, input int unsigned want,
                                  input bit drain);
    int unsigned got;
    int unsigned r;
    int unsigned len;
    logic [15:0] code;
    logic [7:0]  raw;
    got = 0;
    while (got < want) begin
      r    = $urandom_range(0, 99);
      len  = $urandom_range(1, MaxCodeW);
      code = 16'($urandom) & 16'((32'd1 << len) - 32'd1);
      raw  = ($urandom_range(0, 3) == 0) ? StuffMark : 8'($urandom);
      if (r < 70) begin
        // all-ones codes drive the stuffing path hard
        if ($urandom_range(0, 4) == 0) code = 16'((32'd1 << len) - 32'd1);
        add_beat(ACT_PUT, code, 5'(len), 8'($urandom), drain && got == 0, phase);
        got++;
      end else if (r < 76) begin
        add_beat(ACT_PUT, 16'($urandom), 5'($urandom_range(1, 31)), 8'($urandom),
                 drain && got == 0, phase);
        got++;
      end else if (r < 87) begin
        add_beat(ACT_ALIGN, 16'($urandom), 5'($urandom), 8'($urandom),
                 drain && got == 0, phase);
        got++;
      end else if (r < 96) begin
        add_beat(ACT_RAW, 16'($urandom), 5'($urandom), raw, drain && got == 0, phase);
        got++;
      end else if (r < 98) begin
        add_beat(ActUnused, 16'($urandom), 5'($urandom), 8'($urandom), 1'b0, phase);
      end else begin
        add_beat(ACT_PUT, 16'($urandom), 5'd0, 8'($urandom), 1'b0, phase);
      end
    end
  endtask

  // Driver: hold a beat until it is taken, then offer the next one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
      cur_phase     <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pack_expected_bytes(in_if.payload);
        beats_in++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (pending_beats_q.size() != 0
            && !(pending_beats_q[0].drain_first && expected_bytes_q.size() != 0)
            && $urandom_range(0, 99) >= src_idle_pct[pending_beats_q[0].phase]) begin
          in_if.payload <= pending_beats_q[0].beat;
          cur_phase     <= pending_beats_q[0].phase;
          in_if.valid   <= 1'b1;
          pending_beats_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output beat against the oldest expected byte.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    jbp_out_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        bytes_out++;
        if (expected_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                    out_if.payload.out_byte, out_if.payload.last));
        end else begin
          want = expected_bytes_q.pop_front();
          if (out_if.payload.out_byte !== want.out_byte)
            report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h", bytes_out,
                                      out_if.payload.out_byte, want.out_byte));
          if (out_if.payload.last !== want.last)
            report_mismatch($sformatf("byte %0d: last %0b, want %0b", bytes_out,
                                      out_if.payload.last, want.last));
        end
      end
      out_if.ready <= !sink_hold_r && ($urandom_range(0, 99) >= sink_stall_pct[cur_phase]);
    end
  end

  // Hold the receiver off long enough for the block to back up into its input.
  initial begin : sink_hold_proc
    sink_hold_r = 1'b0;
    while (beats_in < 30) @(posedge clk_i);
    sink_hold_r <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    sink_hold_r <= 1'b0;
  end

  always @(posedge clk_i) begin : watchdog_proc
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == StallLimit) begin
        $display("timeout: no beat moved for %0d cycles, %0d bytes still due",
                 StallLimit, expected_bytes_q.size());
        $display("testbench failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : main_proc
    packed_bits_r = '0;
    held_cnt_r    = '0;
    stall_cycles  = 0;
    err_cnt       = 0;
    beats_in      = 0;
    bytes_out     = 0;
    stuff_cnt     = 0;
    n_put         = 0;
    n_align       = 0;
    n_raw         = 0;
    n_ignored     = 0;

    // Directed: stuffing, alignment corners, raw bytes, ignored beats.
    add_beat(ACT_PUT,   16'hFFFF, 5'd16, 8'h00, 1'b0, 0);  // four bytes out
    add_beat(ACT_ALIGN, 16'h0000, 5'd0,  8'h00, 1'b0, 0);  // empty: nothing
    add_beat(ACT_PUT,   16'h0001, 5'd1,  8'h00, 1'b0, 0);
    add_beat(ACT_PUT,   16'h007F, 5'd7,  8'h00, 1'b0, 0);
    add_beat(ACT_ALIGN, 16'h0000, 5'd0,  8'h00, 1'b0, 0);  // full byte held
    add_beat(ACT_PUT,   16'hFFFF, 5'd0,  8'hFF, 1'b0, 0);  // zero length
    add_beat(ACT_PUT,   16'hABCD, 5'd31, 8'h00, 1'b0, 0);  // clamp to 16
    add_beat(ACT_PUT,   16'hFFFD, 5'd3,  8'h00, 1'b0, 0);  // stray upper bits
    add_beat(ACT_RAW,   16'hFFFF, 5'd31, 8'hFF, 1'b0, 0);  // raw 0xFF, no stuff
    add_beat(ACT_RAW,   16'h0000, 5'd0,  8'h00, 1'b0, 0);
    add_beat(ActUnused, 16'hFFFF, 5'd31, 8'hFF, 1'b0, 0);
    add_beat(ACT_ALIGN, 16'hFFFF, 5'd31, 8'hFF, 1'b0, 0);  // pad five ones
    add_beat(ACT_PUT,   16'h0ABC, 5'd12, 8'h00, 1'b0, 0);
    add_beat(ACT_ALIGN, 16'h0000, 5'd0,  8'h00, 1'b0, 0);  // pad fills the word
    add_beat(ACT_PUT,   16'h0000, 5'd5,  8'h00, 1'b0, 0);
    add_beat(ACT_PUT,   16'h07FF, 5'd11, 8'h00, 1'b0, 0);
    add_beat(ACT_PUT,   16'h7FFF, 5'd15, 8'h00, 1'b0, 0);
    add_beat(ACT_PUT,   16'h0001, 5'd1,  8'h00, 1'b0, 0);
    add_beat(ACT_PUT,   16'h0005, 5'd16, 8'hFF, 1'b0, 0);
    add_beat(ACT_ALIGN, 16'h1234, 5'd9,  8'h5A, 1'b0, 0);
    add_beat(ACT_PUT,   16'h0003, 5'd2,  8'h00, 1'b0, 0);
    add_beat(ACT_ALIGN, 16'h0000, 5'd0,  8'h00, 1'b0, 0);  // pad yields 0xFF
    add_beat(ACT_RAW,   16'hC3C3, 5'd17, 8'hA5, 1'b0, 0);

    add_random_beats(0, 40, 1'b0);
    add_random_beats(1, 50, 1'b1);
    add_random_beats(2, 50, 1'b1);
    add_random_beats(3, 50, 1'b1);

    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_beats_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_bytes_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes_q.size()));

    $display("covered %0d beats: %0d puts, %0d aligns, %0d raw, %0d unused action",
             beats_in, n_put, n_align, n_raw, n_ignored);
    $display("checked %0d output bytes (%0d stuff bytes) over four idle/stall phases",
             bytes_out, stuff_cnt);
    if (err_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/jbp_pkg.sv
src/jbp_stream_if.sv
src/jbp_front.sv
src/jbp_job_fifo.sv
src/jbp_back.sv
src/jpeg_bit_packer_with_stuffing_top.sv
src/jbp_checker.sv
verif/testbench.sv
